// ===== design/nrcw_pkg.sv =====
// Shared widths, codes, reset values and types for the NewReno congestion window unit.
package nrcw_pkg;

   // Field widths
   localparam int unsigned OP_W       = 2;
   localparam int unsigned ACK_W      = 32;
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned WIN_W      = 48;
   localparam int unsigned MDB_W      = 16;
   localparam int unsigned IW_W       = 21;
   localparam int unsigned MW_W       = 17;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 21;

   // Divider sizing: one quotient bit per step
   localparam int unsigned DIV_STEPS = WIN_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   // Event codes
   localparam logic [OP_W-1:0] OP_ACK     = 2'd0;
   localparam logic [OP_W-1:0] OP_LOSS    = 2'd1;
   localparam logic [OP_W-1:0] OP_PERSIST = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DATAGRAM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_WINDOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WINDOW   = 2'd2;

   // Reset values
   localparam logic [MDB_W-1:0] MDB_RESET      = 16'd1200;
   localparam logic [IW_W-1:0]  INIT_WIN_RESET = 21'd12000;
   localparam logic [MW_W-1:0]  MIN_WIN_RESET  = 17'd2400;
   localparam logic [WIN_W-1:0] WIN_ALL_ONES   = {WIN_W{1'b1}};

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== design/nrcw_divider.sv =====
// Iterative restoring divider: one quotient bit per cycle through a shared subtractor.
module nrcw_divider
   import nrcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WIN_W-1:0]     dividend,
   input  logic [WIN_W-1:0]     divisor,
   output div_status_type       status,
   output logic [WIN_W-1:0]     quotient
);

   logic [WIN_W-1:0]     rem_ff, rem_in;
   logic [WIN_W-1:0]     quo_ff, quo_in;
   logic [WIN_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [WIN_W:0]       shifted;
   logic [WIN_W:0]       diff;
   logic                 ge;

   // Shared subtract and compare: remainder shifted left, dividend bit in
   assign shifted = {rem_ff, quo_ff[WIN_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         dvs_in   = divisor;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[WIN_W-1:0] : shifted[WIN_W-1:0];
         quo_in   = {quo_ff[WIN_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== design/newreno_congestion_window_unit.sv =====
// Sequence: an ack in slow start passes EVAL and ADD before RESPOND; loss, persistent
// congestion, an ack held in recovery and the unused code pass EVAL only before RESPOND.
// An ack in congestion avoidance passes EVAL, START, the 48-step serial divider and ADD.
// Flow: one word at a time; req_ready is high only while idle, so a new event word is
// accepted only after the response word to the last one has been taken.
// Reset: synchronous; window 12000, threshold all ones, not recovering, registers at
module newreno_congestion_window_unit
   import nrcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ACK_W-1:0]      req_acked_bytes,
   input  logic [TIME_W-1:0]     req_sent_time_ms,
   input  logic [TIME_W-1:0]     req_now_ms,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WIN_W-1:0]      rsp_window_bytes,
   output logic [WIN_W-1:0]      rsp_slow_start_threshold,
   output logic                  rsp_recovering,
   output logic                  rsp_loss_applied,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   // their defaults. A reset always reloads the default initial window.

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_EVAL    = 6'b000010,
      ST_START   = 6'b000100,
      ST_DIVIDE  = 6'b001000,
      ST_ADD     = 6'b010000,
      ST_RESPOND = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [ACK_W-1:0]     acked_ff, acked_in;
   logic [TIME_W-1:0]    sent_ff, sent_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [WIN_W-1:0]     threshold_ff, threshold_in;
   logic                 recov_ff, recov_in;
   logic [TIME_W-1:0]    rec_start_ff, rec_start_in;
   logic                 applied_ff, applied_in;
   logic [WIN_W-1:0]     inc_ff, inc_in;
   logic [WIN_W-1:0]     product_ff, product_in;
   logic [MDB_W-1:0]     mdb_ff, mdb_in;
   logic [MW_W-1:0]      minwin_ff, minwin_in;

   logic                 div_start;
   div_status_type       div_status;
   logic [WIN_W-1:0]     div_quotient;

   logic                 req_fire;
   logic [WIN_W:0]       sum;
   logic [WIN_W-1:0]     half;
   logic [WIN_W-1:0]     min_ext;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == ST_RESPOND);

   // Saturating growth and loss halving
   assign sum     = {1'b0, window_ff} + {1'b0, inc_ff};
   assign min_ext = {{(WIN_W-MW_W){1'b0}}, minwin_ff};
   assign half    = ((window_ff >> 1) < min_ext) ? min_ext : (window_ff >> 1);

   // Configuration writes; the initial window index is taken and has no effect,
   // since reset restores the default before the window reloads
   always_comb begin
      mdb_in    = mdb_ff;
      minwin_in = minwin_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_DATAGRAM: mdb_in    = csr_data[MDB_W-1:0];
            CSR_MIN_WINDOW:   minwin_in = csr_data[MW_W-1:0];
            CSR_INIT_WINDOW:  ;
            default:          ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      acked_in     = acked_ff;
      sent_in      = sent_ff;
      now_in       = now_ff;
      window_in    = window_ff;
      threshold_in = threshold_ff;
      recov_in     = recov_ff;
      rec_start_in = rec_start_ff;
      applied_in   = applied_ff;
      inc_in       = inc_ff;
      product_in   = product_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in      = req_operation;
               acked_in   = req_acked_bytes;
               sent_in    = req_sent_time_ms;
               now_in     = req_now_ms;
               applied_in = 1'b0;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // multiplier output is registered before the divider sees it
            product_in = WIN_W'(mdb_ff) * WIN_W'(acked_ff);
            state_in   = ST_RESPOND;
            unique case (op_ff)
               OP_ACK: begin
                  if (recov_ff && !(sent_ff > rec_start_ff)) begin
                     // still recovering: no growth
                  end else begin
                     recov_in = 1'b0;
                     if (window_ff < threshold_ff || window_ff == '0) begin
                        inc_in   = {{(WIN_W-ACK_W){1'b0}}, acked_ff};
                        state_in = ST_ADD;
                     end else begin
                        state_in = ST_START;
                     end
                  end
               end
               OP_LOSS: begin
                  if (!recov_ff && !(sent_ff < rec_start_ff)) begin
                     threshold_in = half;
                     window_in    = half;
                     recov_in     = 1'b1;
                     rec_start_in = now_ff;
                     applied_in   = 1'b1;
                  end
               end
               OP_PERSIST: window_in = min_ext;
               default: ;
            endcase
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               inc_in   = div_quotient;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            window_in = sum[WIN_W] ? WIN_ALL_ONES : sum[WIN_W-1:0];
            state_in  = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= {{(WIN_W-IW_W){1'b0}}, INIT_WIN_RESET};
         threshold_ff <= WIN_ALL_ONES;
         recov_ff     <= 1'b0;
         rec_start_ff <= '0;
         applied_ff   <= 1'b0;
         mdb_ff       <= MDB_RESET;
         minwin_ff    <= MIN_WIN_RESET;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         threshold_ff <= threshold_in;
         recov_ff     <= recov_in;
         rec_start_ff <= rec_start_in;
         applied_ff   <= applied_in;
         mdb_ff       <= mdb_in;
         minwin_ff    <= minwin_in;
      end
      op_ff      <= op_in;
      acked_ff   <= acked_in;
      sent_ff    <= sent_in;
      now_ff     <= now_in;
      inc_ff     <= inc_in;
      product_ff <= product_in;
   end

   // Avoidance growth: datagram * acked / window
   nrcw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_ff),
      .divisor  (window_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Response word comes straight from the state registers
   assign rsp_window_bytes         = window_ff;
   assign rsp_slow_start_threshold = threshold_ff;
   assign rsp_recovering           = recov_ff;
   assign rsp_loss_applied         = applied_ff;

endmodule

// ===== design/nrcw_checker.sv =====
// Port-level checks for the congestion window unit, bound to the top level.
module nrcw_checker
   import nrcw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WIN_W-1:0]  rsp_window_bytes,
   input logic [WIN_W-1:0]  rsp_slow_start_threshold,
   input logic              rsp_recovering,
   input logic              rsp_loss_applied
);

   // one word in flight: no new request while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   // an accepted request leaves the unit not ready in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

   // a stalled response stays valid and its window bytes hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_window_bytes)))
      else $error("stalled response changed");

   // an applied loss starts recovery
   a_loss_recovers: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_loss_applied) |-> rsp_recovering)
      else $error("applied loss without recovery");

   // an applied loss sets window and threshold alike
   a_loss_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_loss_applied) |-> (rsp_window_bytes == rsp_slow_start_threshold))
      else $error("applied loss with window unlike threshold");

endmodule

bind newreno_congestion_window_unit nrcw_checker u_nrcw_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_valid                (req_valid),
   .req_ready                (req_ready),
   .rsp_valid                (rsp_valid),
   .rsp_ready                (rsp_ready),
   .rsp_window_bytes         (rsp_window_bytes),
   .rsp_slow_start_threshold (rsp_slow_start_threshold),
   .rsp_recovering           (rsp_recovering),
   .rsp_loss_applied         (rsp_loss_applied)
);

// ===== tb/sv/newreno_congestion_window_unit_tb.sv =====
// Self-checking testbench for the NewReno congestion window unit.
`timescale 1ns / 100ps

module newreno_congestion_window_unit_tb;
   import nrcw_pkg::*;

   // Codes and the all-ones time, which have no name in the package
   localparam logic [OP_W-1:0]      OP_UNUSED        = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;
   localparam logic [TIME_W-1:0]    TIME_ALL_ONES    = {TIME_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [ACK_W-1:0]  acked_bytes;
      logic [TIME_W-1:0] sent_time_ms;
      logic [TIME_W-1:0] now_ms;
   } cc_event_type;

   typedef struct packed {
      logic [WIN_W-1:0] window_bytes;
      logic [WIN_W-1:0] slow_start_threshold;
      logic             recovering;
      logic             loss_applied;
   } cc_result_type;

   // DUT ports
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation = '0;
   logic [ACK_W-1:0]      req_acked_bytes = '0;
   logic [TIME_W-1:0]     req_sent_time_ms = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   logic [WIN_W-1:0]      rsp_window_bytes;
   logic [WIN_W-1:0]      rsp_slow_start_threshold;
   logic                  rsp_recovering;
   logic                  rsp_loss_applied;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Window state as the unit should hold it
   logic [WIN_W-1:0]  cwnd;
   logic [WIN_W-1:0]  ssthresh;
   logic              recovery_active;
   logic [TIME_W-1:0] recovery_start_ms;
   logic [MDB_W-1:0]  max_datagram;
   logic [IW_W-1:0]   initial_window;
   logic [MW_W-1:0]   min_window;

   cc_result_type     expected_results[$];
   int                mismatch_count = 0;
   logic              idling_on = 1'b1;
   int                stall_cycles = 0;
   logic [TIME_W-1:0] wall_ms;

   newreno_congestion_window_unit DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_operation            (req_operation),
      .req_acked_bytes          (req_acked_bytes),
      .req_sent_time_ms         (req_sent_time_ms),
      .req_now_ms               (req_now_ms),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_window_bytes         (rsp_window_bytes),
      .rsp_slow_start_threshold (rsp_slow_start_threshold),
      .rsp_recovering           (rsp_recovering),
      .rsp_loss_applied         (rsp_loss_applied),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   always #2 clock = ~clock;

   // Apply one event to the window state and return the word it should produce
   function automatic cc_result_type predict_window_update(cc_event_type ev);
      cc_result_type    res;
      logic [WIN_W-1:0] mdb_wide;
      logic [WIN_W-1:0] acked_wide;
      logic [WIN_W-1:0] min_wide;
      logic [WIN_W-1:0] growth;
      logic [WIN_W:0]   sum;
      logic [WIN_W-1:0] half;
      logic             applied;
      applied    = 1'b0;
      mdb_wide   = {{(WIN_W-MDB_W){1'b0}}, max_datagram};
      acked_wide = {{(WIN_W-ACK_W){1'b0}}, ev.acked_bytes};
      min_wide   = {{(WIN_W-MW_W){1'b0}}, min_window};
      case (ev.operation)
         OP_ACK: begin
            // an ack for a packet sent after recovery began ends recovery
            if (recovery_active && ev.sent_time_ms > recovery_start_ms)
               recovery_active = 1'b0;
            if (!recovery_active) begin
               if (cwnd < ssthresh || cwnd == '0)
                  growth = acked_wide;
               else
                  growth = (mdb_wide * acked_wide) / cwnd;
               sum  = {1'b0, cwnd} + {1'b0, growth};
               cwnd = sum[WIN_W] ? WIN_ALL_ONES : sum[WIN_W-1:0];
            end
         end
         OP_LOSS: begin
            if (!recovery_active && ev.sent_time_ms >= recovery_start_ms) begin
               half = cwnd >> 1;
               if (half < min_wide)
                  half = min_wide;
               ssthresh          = half;
               cwnd              = half;
               recovery_active   = 1'b1;
               recovery_start_ms = ev.now_ms;
               applied           = 1'b1;
            end
         end
         OP_PERSIST: cwnd = min_wide;
         default: ;
      endcase
      res.window_bytes         = cwnd;
      res.slow_start_threshold = ssthresh;
      res.recovering           = recovery_active;
      res.loss_applied         = applied;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 40)
         $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Send one event word; valid stays high on return so the next word can follow
   task automatic send_event(input logic [OP_W-1:0] op_code, input logic [ACK_W-1:0] acked,
                             input logic [TIME_W-1:0] sent_ms,
                             input logic [TIME_W-1:0] stamp_ms);
      cc_event_type ev;
      ev.operation    = op_code;
      ev.acked_bytes  = acked;
      ev.sent_time_ms = sent_ms;
      ev.now_ms       = stamp_ms;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op_code;
      req_acked_bytes  <= acked;
      req_sent_time_ms <= sent_ms;
      req_now_ms       <= stamp_ms;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_window_update(ev));
   endtask

   // Stop sending and wait until every expected word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_DATAGRAM: max_datagram   = data[MDB_W-1:0];
         CSR_INIT_WINDOW:  initial_window = data[IW_W-1:0];
         CSR_MIN_WINDOW:   min_window     = data[MW_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Result channel back-pressure: rsp_ready dropped in random bursts that start only while idling_on is set
   always @(posedge clock) begin
      if (stall_cycles != 0) begin
         stall_cycles <= stall_cycles - 1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         rsp_ready    <= 1'b0;
         stall_cycles <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin : result_check
      cc_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result word with none expected", 64'(rsp_window_bytes), '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_window_bytes !== want.window_bytes)
               report_mismatch("window_bytes", 64'(rsp_window_bytes),
                               64'(want.window_bytes));
            if (rsp_slow_start_threshold !== want.slow_start_threshold)
               report_mismatch("slow_start_threshold", 64'(rsp_slow_start_threshold),
                               64'(want.slow_start_threshold));
            if (rsp_recovering !== want.recovering)
               report_mismatch("recovering", 64'(rsp_recovering), 64'(want.recovering));
            if (rsp_loss_applied !== want.loss_applied)
               report_mismatch("loss_applied", 64'(rsp_loss_applied),
                               64'(want.loss_applied));
         end
      end
   end

   // State right after reset: unused code reports it, then slow start growth
   task automatic test_reset_state();
      send_event(OP_UNUSED, '0, '0, '0);
      send_event(OP_ACK, '0, '0, '0);
      send_event(OP_ACK, 32'd1000, '0, '0);
   endtask

   // Max acks in slow start push the window far past 32 bits, then a loss from there
   task automatic test_slow_start_saturation();
      idling_on <= 1'b0;
      repeat (16)
         send_event(OP_ACK, '1, '0, '0);
      send_event(OP_ACK, '1, '0, '0);
      wall_ms = TIME_W'(100);
      send_event(OP_LOSS, '0, wall_ms, wall_ms);
      send_event(OP_ACK, 32'd5000, wall_ms - 1, wall_ms);
      send_event(OP_ACK, 32'd5000, wall_ms, wall_ms);
      // sent after recovery start: leaves recovery, window equals threshold
      send_event(OP_ACK, 32'd1000, wall_ms + 1, wall_ms + 2);
      send_event(OP_ACK, '1, wall_ms + 2, wall_ms + 2);
      send_event(OP_PERSIST, '0, wall_ms, wall_ms + 3);
      send_event(OP_ACK, 32'd3000, wall_ms + 3, wall_ms + 3);
      idling_on <= 1'b1;
   endtask

   // Losses inside recovery or for packets sent before it are ignored
   task automatic test_loss_rules();
      wall_ms = TIME_W'(1000);
      send_event(OP_LOSS, '0, wall_ms, wall_ms);
      send_event(OP_LOSS, '0, wall_ms + 5, wall_ms + 5);
      send_event(OP_ACK, 32'd1200, recovery_start_ms - 1, wall_ms + 6);
      send_event(OP_UNUSED, '1, '1, '1);
      send_event(OP_PERSIST, '0, wall_ms, wall_ms + 7);
      send_event(OP_ACK, 32'd2400, recovery_start_ms + 1, wall_ms + 8);
      send_event(OP_LOSS, '0, recovery_start_ms - 1, wall_ms + 9);
      send_event(OP_LOSS, '0, recovery_start_ms, wall_ms + 10);
      wall_ms += 10;
   endtask

   // Every register at its top value, an unknown index, and masking of wide data
   task automatic test_register_writes();
      wait_drained();
      write_register(CSR_UNUSED_INDEX, CSR_DATA_W'($urandom_range(0, 21'h1FFFFF)));
      write_register(CSR_MAX_DATAGRAM, 21'h1FFFFF);
      write_register(CSR_INIT_WINDOW, 21'h1FFFFF);
      write_register(CSR_MIN_WINDOW, 21'h1FFFFF);
      wall_ms += 50;
      send_event(OP_ACK, 32'd100, wall_ms, wall_ms);
      send_event(OP_PERSIST, '0, wall_ms, wall_ms);
      send_event(OP_LOSS, '0, wall_ms, wall_ms);
      wall_ms += 20;
      send_event(OP_ACK, 32'd60000, wall_ms, wall_ms);
      send_event(OP_ACK, '1, wall_ms, wall_ms);
      wait_drained();
      write_register(CSR_INIT_WINDOW, '0);
   endtask

   // Zero floor drives window and threshold to zero; growth from a zero window skips the divide
   task automatic test_zero_window();
      wait_drained();
      write_register(CSR_MAX_DATAGRAM, 21'd65535);
      write_register(CSR_MIN_WINDOW, '0);
      wall_ms += 50;
      send_event(OP_ACK, '0, wall_ms, wall_ms);
      send_event(OP_PERSIST, '0, wall_ms, wall_ms);
      send_event(OP_ACK, '0, wall_ms, wall_ms);
      send_event(OP_ACK, 32'd1, wall_ms, wall_ms);
      send_event(OP_LOSS, '0, wall_ms, wall_ms);
      wall_ms += 1;
      send_event(OP_ACK, '0, wall_ms, wall_ms);
      send_event(OP_ACK, 32'd1, wall_ms, wall_ms);
      send_event(OP_ACK, '1, wall_ms, wall_ms);
      wait_drained();
      write_register(CSR_MAX_DATAGRAM, {{(CSR_DATA_W-MDB_W){1'b0}}, MDB_RESET});
      write_register(CSR_MIN_WINDOW, {{(CSR_DATA_W-MW_W){1'b0}}, MIN_WIN_RESET});
   endtask

   // Mostly well-formed traffic (acks trailing a moving clock, losses, resets of the
   // window) with some noise; register settings change between phases
   task automatic test_random_traffic();
      int                phase;
      int                n;
      int                pick;
      int                rtt;
      logic [OP_W-1:0]   op_code;
      logic [ACK_W-1:0]  acked;
      logic [TIME_W-1:0] sent_ms;
      wall_ms += $urandom;
      for (phase = 0; phase < 6; phase++) begin
         idling_on <= (phase != 5);
         wait_drained();
         write_register(CSR_INIT_WINDOW, CSR_DATA_W'($urandom_range(0, 21'h1FFFFF)));
         case (phase)
            0: begin
               write_register(CSR_MAX_DATAGRAM, {{(CSR_DATA_W-MDB_W){1'b0}}, MDB_RESET});
               write_register(CSR_MIN_WINDOW, {{(CSR_DATA_W-MW_W){1'b0}}, MIN_WIN_RESET});
            end
            1: begin
               write_register(CSR_MAX_DATAGRAM, 21'd65535);
               write_register(CSR_MIN_WINDOW, 21'd131071);
            end
            2: begin
               write_register(CSR_MAX_DATAGRAM, 21'd1);
               write_register(CSR_MIN_WINDOW, 21'd1);
               write_register(CSR_UNUSED_INDEX,
                              CSR_DATA_W'($urandom_range(0, 21'h1FFFFF)));
            end
            3: begin
               write_register(CSR_MAX_DATAGRAM, '0);
               write_register(CSR_MIN_WINDOW, '0);
            end
            4: begin
               write_register(CSR_MAX_DATAGRAM, CSR_DATA_W'($urandom_range(1200, 65535)));
               write_register(CSR_MIN_WINDOW, CSR_DATA_W'($urandom_range(1200, 131070)));
            end
            default: begin
               write_register(CSR_MAX_DATAGRAM, CSR_DATA_W'($urandom_range(0, 21'h1FFFFF)));
               write_register(CSR_MIN_WINDOW, CSR_DATA_W'($urandom_range(0, 21'h1FFFFF)));
            end
         endcase
         for (n = 0; n < 225; n++) begin
            if (n % 50 == 0 && n != 0 && phase != 5)
               idling_on <= ($urandom_range(0, 3) != 0);
            wall_ms += $urandom_range(0, 20);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               // noise: any code, raw fields
               send_event(OP_W'($urandom_range(0, 3)), $urandom,
                          TIME_W'({$urandom, $urandom}), wall_ms);
            end else begin
               rtt     = $urandom_range(1, 150);
               sent_ms = (wall_ms > rtt) ? wall_ms - rtt : '0;
               pick    = $urandom_range(0, 99);
               op_code = (pick < 82) ? OP_ACK : (pick < 95) ? OP_LOSS : OP_PERSIST;
               pick    = $urandom_range(0, 99);
               if (pick < 60)
                  acked = $urandom_range(1, 3000);
               else if (pick < 85)
                  acked = $urandom_range(0, 65535);
               else
                  acked = $urandom;
               send_event(op_code, acked, sent_ms, wall_ms);
            end
         end
      end
   endtask

   // Times at the top of the range; leaves recovery starting near the end of time
   task automatic test_extreme_times();
      send_event(OP_ACK, '1, TIME_ALL_ONES, TIME_ALL_ONES);
      send_event(OP_LOSS, '0, TIME_ALL_ONES, TIME_ALL_ONES - 1);
      send_event(OP_ACK, 32'd1500, TIME_ALL_ONES - 1, TIME_ALL_ONES);
      send_event(OP_LOSS, '0, TIME_ALL_ONES - 2, TIME_ALL_ONES - 2);
      send_event(OP_ACK, 32'd1500, TIME_ALL_ONES, '0);
   endtask

   initial begin : stimulus
      cwnd              = {{(WIN_W-IW_W){1'b0}}, INIT_WIN_RESET};
      ssthresh          = WIN_ALL_ONES;
      recovery_active   = 1'b0;
      recovery_start_ms = '0;
      max_datagram      = MDB_RESET;
      initial_window    = INIT_WIN_RESET;
      min_window        = MIN_WIN_RESET;
      wall_ms           = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_slow_start_saturation();
      test_loss_rules();
      test_register_writes();
      test_zero_window();
      test_random_traffic();
      test_extreme_times();
      wait_drained();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog: a correct run takes well under a millisecond
   initial begin : watchdog
      #25_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
